>>> sv/shg_pkg.sv
`default_nettype none

package shg_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 13;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W = 13;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] grad;
    logic last;
  } result_t;

  // (rt + 2*rm + rb) - (lt + 2*lm + lb), clamped to the pixel range
  function automatic logic [PIX_W-1:0] sobel_grad(
    input logic [PIX_W-1:0] lt,
    input logic [PIX_W-1:0] lm,
    input logic [PIX_W-1:0] lb,
    input logic [PIX_W-1:0] rt,
    input logic [PIX_W-1:0] rm,
    input logic [PIX_W-1:0] rb
  );
    logic [PIX_W+1:0] l;
    logic [PIX_W+1:0] r;
    logic signed [PIX_W+2:0] d;
    l = {2'b00, lt} + {1'b0, lm, 1'b0} + {2'b00, lb};
    r = {2'b00, rt} + {1'b0, rm, 1'b0} + {2'b00, rb};
    d = signed'({1'b0, r}) - signed'({1'b0, l});
    if (d < 0) begin
      return '0;
    end else if (d > signed'({3'b000, PIX_MAX})) begin
      return PIX_MAX;
    end else begin
      return d[PIX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/sobel_horizontal_gradient_3x3.sv
`default_nettype none

// Horizontal 3x3 Sobel gradient (-1 0 1 / -2 0 2 / -1 0 1) over a raster stream of 8-bit
// pixels, clamped to 0..255, edges replicated. Results leave one row behind the input; after
// the last row, one drain item (mode=1) per column flushes the final row, and the result for
// the last column carries frame_last. One item is taken per clock: the two line stores are
// single-write memories read with registered data, the 3x3 window and the gradient sit in
// the stage after that read, and a 4-entry result queue absorbs the end-of-row item that
// yields two results. The first item of a row yields none, so while the output is taken at
// one result per clock the input never stalls; it stalls only while an item waits in the
// read stage and the queue holds three or more results. A result passes through the read
// stage and the result queue before it is offered. Configuration takes effect at once and is
// meant to change between frames.
module sobel_horizontal_gradient_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        write_enable,
  input  wire logic                        register_index,
  input  wire logic [shg_pkg::CFG_W-1:0]   write_data,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        mode,
  input  wire logic [shg_pkg::PIX_W-1:0]   pixel_in,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [shg_pkg::PIX_W-1:0]   gradient_out,
  output      logic                        frame_last
);
  import shg_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;
  localparam int QD = 4;
  localparam int QA = 2;

  // configuration
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;

  // counters
  logic [XW-1:0]       column_count;
  logic [XW-1:0]       drain_count;
  logic [HEIGHT_W-1:0] row_count;

  // line stores
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic             pend_we;
  logic [XW-1:0]    pend_addr;

  // read stage
  logic             s1_valid;
  logic             s1_mode;
  logic             s1_ok;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_first;
  logic             s1_xge1;
  logic             s1_xlast;
  logic             s1_r1;
  logic             s1_r2;
  logic [PIX_W-1:0] rd_na;
  logic [PIX_W-1:0] rd_nb;
  logic [PIX_W-1:0] rd_oa;
  logic [PIX_W-1:0] rd_ob;

  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] win_next [9];

  // result queue
  result_t      queue [QD];
  logic [QA-1:0] rd_ptr;
  logic [QA-1:0] wr_ptr;
  logic [QA:0]   q_count;

  logic [WW-1:0]       width_ext;
  logic [XW-1:0]       last_col;
  logic [HEIGHT_W-1:0] h_eff;
  logic [XW-1:0]       x;
  logic [XW-1:0]       xd;
  logic [XW-1:0]       xl;
  logic [XW-1:0]       xr;
  logic [XW-1:0]       addr_a;
  logic [XW-1:0]       addr_b;
  logic                pixel_ok;
  logic                drain_ok;
  logic                in_xfer;
  logic                out_xfer;
  logic                s1_adv;

  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] tp_l;
  logic [PIX_W-1:0] tp_r;
  result_t          res0;
  result_t          res1;
  logic [1:0]       push_n;

  always_comb begin
    width_ext = WW'(image_width);
    if (image_width == '0) begin
      last_col = '0;
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      last_col = XW'(MAX_WIDTH - 1);
    end else begin
      last_col = XW'(width_ext - WW'(1));
    end
    if (image_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (image_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end
  end

  always_comb begin
    x  = (column_count < last_col) ? column_count : last_col;
    xd = (drain_count < last_col) ? drain_count : last_col;
    xl = (xd != '0) ? xd - XW'(1) : '0;
    xr = (xd < last_col) ? xd + XW'(1) : last_col;
    pixel_ok = row_count < h_eff;
    drain_ok = !pixel_ok;
    if (mode == MODE_DRAIN) begin
      addr_a = xl;
      addr_b = xr;
    end else begin
      addr_a = x;
      addr_b = x;
    end
  end

  assign s1_adv   = s1_valid && (q_count <= (QA+1)'(QD - 2));
  assign in_stall = s1_valid && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = q_count != '0;
  assign out_xfer  = out_valid && !out_stall;
  assign gradient_out = queue[rd_ptr].grad;
  assign frame_last   = queue[rd_ptr].last;

  // line stores: newer written on a pixel transfer, older gets the displaced newer value in the next cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_na <= newer_mem[addr_a];
      rd_nb <= newer_mem[addr_b];
      if (pend_we && pend_addr == addr_a) begin
        rd_oa <= rd_na;
      end else begin
        rd_oa <= older_mem[addr_a];
      end
      if (pend_we && pend_addr == addr_b) begin
        rd_ob <= rd_na;
      end else begin
        rd_ob <= older_mem[addr_b];
      end
      if (mode == MODE_PIXEL && pixel_ok) begin
        newer_mem[x] <= pixel_in;
      end
    end
    if (pend_we) begin
      older_mem[pend_addr] <= rd_na;
    end
  end

  // window update and gradients
  always_comb begin
    mid  = rd_na;
    top  = s1_r2 ? rd_oa : rd_na;
    tp_l = s1_r2 ? rd_oa : rd_na;
    tp_r = s1_r2 ? rd_ob : rd_nb;
    for (int i = 0; i < 9; i++) begin
      win_next[i] = win[i];
    end
    if (s1_first) begin
      for (int c = 0; c < 3; c++) begin
        win_next[c*3]     = top;
        win_next[c*3 + 1] = mid;
        win_next[c*3 + 2] = s1_pix;
      end
    end else begin
      for (int i = 0; i < 6; i++) begin
        win_next[i] = win[i + 3];
      end
      win_next[6] = top;
      win_next[7] = mid;
      win_next[8] = s1_pix;
    end

    res0 = '0;
    res1 = '0;
    push_n = 2'd0;
    if (s1_adv && s1_ok) begin
      if (s1_mode == MODE_DRAIN) begin
        res0.grad = sobel_grad(tp_l, rd_na, rd_na, tp_r, rd_nb, rd_nb);
        res0.last = s1_xlast;
        push_n = 2'd1;
      end else if (s1_r1) begin
        if (s1_xge1 && s1_xlast) begin
          res0.grad = sobel_grad(win_next[0], win_next[1], win_next[2],
                                 win_next[6], win_next[7], win_next[8]);
          res1.grad = sobel_grad(win_next[3], win_next[4], win_next[5],
                                 win_next[6], win_next[7], win_next[8]);
          push_n = 2'd2;
        end else if (s1_xge1) begin
          res0.grad = sobel_grad(win_next[0], win_next[1], win_next[2],
                                 win_next[6], win_next[7], win_next[8]);
          push_n = 2'd1;
        end else if (s1_xlast) begin
          res0.grad = sobel_grad(win_next[3], win_next[4], win_next[5],
                                 win_next[6], win_next[7], win_next[8]);
          push_n = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode  <= mode;
      s1_pix   <= pixel_in;
      s1_first <= x == '0;
      s1_xge1  <= x != '0;
      s1_xlast <= (mode == MODE_DRAIN) ? (xd == last_col) : (x == last_col);
      s1_r1    <= row_count >= HEIGHT_W'(1);
      s1_r2    <= row_count >= HEIGHT_W'(2);
      s1_ok    <= (mode == MODE_DRAIN) ? drain_ok : pixel_ok;
    end
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QA'(1)] <= res1;
    end
    pend_addr <= x;
    if (rst) begin
      image_width  <= WIDTH_REG_W'(640);
      image_height <= HEIGHT_W'(480);
      column_count <= '0;
      drain_count  <= '0;
      row_count    <= '0;
      pend_we      <= 1'b0;
      s1_valid     <= 1'b0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      q_count      <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (write_enable) begin
        unique case (register_index)
          REG_WIDTH:  image_width  <= write_data[WIDTH_REG_W-1:0];
          REG_HEIGHT: image_height <= write_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      pend_we <= in_xfer && mode == MODE_PIXEL && pixel_ok;
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (in_xfer && mode == MODE_PIXEL && pixel_ok) begin
        if (x == last_col) begin
          column_count <= '0;
          row_count    <= row_count + HEIGHT_W'(1);
        end else begin
          column_count <= x + XW'(1);
        end
      end
      if (in_xfer && mode == MODE_DRAIN && drain_ok) begin
        if (xd == last_col) begin
          column_count <= '0;
          row_count    <= '0;
          drain_count  <= '0;
        end else begin
          drain_count <= xd + XW'(1);
        end
      end
      if (s1_adv && s1_ok && s1_mode == MODE_PIXEL) begin
        win <= win_next;
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + QA'(1);
      end
      wr_ptr  <= wr_ptr + QA'(push_n);
      q_count <= q_count + (QA+1)'(push_n) - (QA+1)'(out_xfer);
    end
  end

endmodule

`default_nettype wire

>>> sim/sobel_horizontal_gradient_3x3_test.sv
`timescale 1ns / 1ps

module sobel_horizontal_gradient_3x3_test;
  import shg_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  // rows 0,0,255 / 255,0,0 / 0,255,255 so both clamps are hit
  localparam logic [71:0] EDGE_PATTERN = {8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255,
                                          8'd255, 8'd0, 8'd0};

  class gradient_scoreboard;
    localparam int ROW_LEN = 1024;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0] older_row [ROW_LEN];
    logic [PIX_W-1:0] newer_row [ROW_LEN];
    // window held column by column, left column first, top row first
    logic [PIX_W-1:0] win [9];
    logic [10:0] col_cnt;
    logic [10:0] drain_cnt;
    logic [12:0] row_cnt;
    result_t pending [$];
    int errors;
    int results_seen;

    function new();
      width_reg = 11'd640;
      height_reg = 13'd480;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = '0;
      drain_cnt = '0;
      row_cnt = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_WIDTH) begin
        width_reg = data[WIDTH_REG_W-1:0];
      end else begin
        height_reg = data[HEIGHT_W-1:0];
      end
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > ROW_LEN) return ROW_LEN;
      return int'(width_reg);
    endfunction

    function int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return int'(MAX_HEIGHT);
      return int'(height_reg);
    endfunction

    function logic [PIX_W-1:0] clamped_diff(int lt, int lm, int lb, int rt, int rm, int rb);
      int s;
      s = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
      if (s < 0) return '0;
      if (s > int'(PIX_MAX)) return PIX_MAX;
      return s[PIX_W-1:0];
    endfunction

    function logic [PIX_W-1:0] window_slope(int lc, int rc);
      return clamped_diff(win[lc*3], win[lc*3+1], win[lc*3+2],
                          win[rc*3], win[rc*3+1], win[rc*3+2]);
    endfunction

    function void queue_result(logic [PIX_W-1:0] g, logic fl);
      result_t r;
      r.grad = g;
      r.last = fl;
      pending.push_back(r);
    endfunction

    function void note_input(logic m, logic [PIX_W-1:0] pix);
      int w, h, x, xl, xr, c;
      logic [PIX_W-1:0] top, mid, tl, tr;
      w = active_width();
      h = active_height();
      if (m == MODE_PIXEL) begin
        // pixels are dropped once the frame waits for its drain
        if (row_cnt >= h) return;
        x = (col_cnt < w - 1) ? int'(col_cnt) : w - 1;
        mid = newer_row[x];
        top = (row_cnt >= 2) ? older_row[x] : mid;
        older_row[x] = newer_row[x];
        newer_row[x] = pix;
        if (x == 0) begin
          // left edge: replicate the first column across the window
          for (c = 0; c < 3; c++) begin
            win[c*3] = top;
            win[c*3+1] = mid;
            win[c*3+2] = pix;
          end
        end else begin
          for (c = 0; c < 6; c++) win[c] = win[c+3];
          win[6] = top;
          win[7] = mid;
          win[8] = pix;
        end
        if (row_cnt >= 1) begin
          if (x >= 1) queue_result(window_slope(0, 2), 1'b0);
          // right edge: last output of the row above
          if (x == w - 1) queue_result(window_slope(1, 2), 1'b0);
        end
        if (x == w - 1) begin
          col_cnt = '0;
          row_cnt = row_cnt + 13'd1;
        end else begin
          col_cnt = 11'(x + 1);
        end
      end else begin
        if (row_cnt < h) return;
        x = (drain_cnt < w - 1) ? int'(drain_cnt) : w - 1;
        xl = (x > 0) ? x - 1 : 0;
        xr = (x + 1 < w) ? x + 1 : w - 1;
        if (row_cnt >= 2) begin
          tl = older_row[xl];
          tr = older_row[xr];
        end else begin
          tl = newer_row[xl];
          tr = newer_row[xr];
        end
        queue_result(clamped_diff(tl, newer_row[xl], newer_row[xl],
                                  tr, newer_row[xr], newer_row[xr]), x == w - 1);
        if (x == w - 1) begin
          col_cnt = '0;
          row_cnt = '0;
          drain_cnt = '0;
        end else begin
          drain_cnt = 11'(x + 1);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(logic [PIX_W-1:0] g, logic fl);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transfer gradient=%0d frame_last=%b", g, fl));
        return;
      end
      want = pending.pop_front();
      if (g !== want.grad) report($sformatf("gradient %0d, want %0d", g, want.grad));
      if (fl !== want.last) report($sformatf("frame_last %b, want %b", fl, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic register_index = REG_WIDTH;
  logic [CFG_W-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_PIXEL;
  logic [PIX_W-1:0] pixel_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] gradient_out;
  logic frame_last;

  gradient_scoreboard sb;
  int stream_items = 0;
  int hold_req = 0;
  bit tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  sobel_horizontal_gradient_3x3 #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .pixel_in(pixel_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .gradient_out(gradient_out),
    .frame_last(frame_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (write_enable) sb.set_register(register_index, write_data);
      if (in_valid && !in_stall) sb.note_input(mode, pixel_in);
      if (out_valid && !out_stall) sb.check_result(gradient_out, frame_last);
    end
  end

  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        // long hold-off so the block fills up and stalls its input
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !rx_calm && ($urandom_range(0, 99) < 36);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? PIX_MAX : '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic m, input logic [PIX_W-1:0] pix, input bit counted);
    while (!tx_calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    pixel_in <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (counted) stream_items++;
  endtask

  task automatic send_run(input logic m, input int n);
    repeat (n) send_item(m, pick_pixel(), 1'b1);
  endtask

  // stop offering and let every expected transfer come out, plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(input int w_reg, input int h_reg);
    write_register(REG_WIDTH, CFG_W'(w_reg));
    write_register(REG_HEIGHT, CFG_W'(h_reg));
  endtask

  task automatic run_frame(input int w_reg, input int h_reg);
    int w, h;
    w = (w_reg == 0) ? 1 : ((w_reg > LINE_MAX) ? LINE_MAX : w_reg);
    h = (h_reg == 0) ? 1 : ((h_reg > int'(MAX_HEIGHT)) ? int'(MAX_HEIGHT) : h_reg);
    settle();
    set_frame_size(w_reg, h_reg);
    repeat (w * h) begin
      // early drain, dropped by the block
      if ($urandom_range(0, 99) < 3) send_item(MODE_DRAIN, pick_pixel(), 1'b0);
      send_item(MODE_PIXEL, pick_pixel(), 1'b1);
      if ($urandom_range(0, 299) == 0) settle();
    end
    repeat (w) begin
      // stray pixel while the frame waits for its drain
      if ($urandom_range(0, 99) < 3) send_item(MODE_PIXEL, pick_pixel(), 1'b0);
      send_item(MODE_DRAIN, pick_pixel(), 1'b1);
    end
  endtask

  initial begin : stimulus
    int i, wsel, hsel, w_reg, h_reg;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_frame_size(3, 3);
    send_item(MODE_DRAIN, PIX_MAX, 1'b0);
    for (i = 0; i < 9; i++) send_item(MODE_PIXEL, EDGE_PATTERN[i*8 +: 8], 1'b1);
    send_item(MODE_PIXEL, PIX_MAX, 1'b0);
    send_run(MODE_DRAIN, 3);

    // single row: drain uses the final row as its own top
    settle();
    set_frame_size(2, 1);
    send_item(MODE_PIXEL, PIX_MAX, 1'b1);
    send_item(MODE_PIXEL, '0, 1'b1);
    send_run(MODE_DRAIN, 2);

    // single column
    settle();
    set_frame_size(1, 3);
    send_item(MODE_PIXEL, '0, 1'b1);
    send_item(MODE_PIXEL, PIX_MAX, 1'b1);
    send_item(MODE_PIXEL, 8'd128, 1'b1);
    send_run(MODE_DRAIN, 1);

    // width shrinks mid-row: the column count past the new end acts as the last column
    settle();
    set_frame_size(6, 4);
    send_run(MODE_PIXEL, 16);
    settle();
    write_register(REG_WIDTH, CFG_W'(3));
    send_run(MODE_PIXEL, 4);
    send_run(MODE_DRAIN, 3);

    // width shrinks mid-drain
    settle();
    set_frame_size(6, 2);
    send_run(MODE_PIXEL, 12);
    send_run(MODE_DRAIN, 4);
    settle();
    write_register(REG_WIDTH, CFG_W'(3));
    send_run(MODE_DRAIN, 1);

    // hold-off starts with nothing pending, the frame is offered while it lasts
    settle();
    hold_req <= hold_req + 1;
    run_frame(16, 8);

    settle();
    tx_calm = 1'b1;
    rx_calm <= 1'b1;
    run_frame(40, 4);
    settle();
    tx_calm = 1'b0;
    rx_calm <= 1'b0;

    stream_items = 0;
    while (stream_items < RANDOM_ITEMS) begin
      wsel = $urandom_range(0, 99);
      hsel = $urandom_range(0, 99);
      if (wsel < 5) w_reg = 0;
      else if (wsel < 75) w_reg = $urandom_range(1, 8);
      else if (wsel < 95) w_reg = $urandom_range(9, 40);
      else w_reg = $urandom_range(41, 100);
      if (hsel < 5) h_reg = 0;
      else if (hsel < 80) h_reg = $urandom_range(1, 5);
      else h_reg = $urandom_range(6, 16);
      run_frame(w_reg, h_reg);
    end

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
